// ===== sv/f8ie_pkg.sv =====
`timescale 1ns / 1ps
package f8ie_pkg;

    localparam int FLAG_W     = 5;
    localparam int FLAG_SIGN  = 0;
    localparam int FLAG_CARRY = 1;
    localparam int FLAG_ZERO  = 2;
    localparam int FLAG_OVF   = 3;
    localparam int FLAG_ICB   = 4;

    localparam int SCRATCH_DEPTH = 64;
    localparam int SCRATCH_AW    = 6;

    // scratchpad registers with fixed roles
    localparam logic [SCRATCH_AW-1:0] SR_J  = 6'd9;
    localparam logic [SCRATCH_AW-1:0] SR_HU = 6'd10;
    localparam logic [SCRATCH_AW-1:0] SR_HL = 6'd11;
    localparam logic [SCRATCH_AW-1:0] SR_KU = 6'd12;
    localparam logic [SCRATCH_AW-1:0] SR_KL = 6'd13;
    localparam logic [SCRATCH_AW-1:0] SR_QU = 6'd14;
    localparam logic [SCRATCH_AW-1:0] SR_QL = 6'd15;

    // register field codes
    localparam logic [3:0] RF_DIRECT_LAST = 4'd11;
    localparam logic [3:0] RF_ISAR_INC    = 4'd13;
    localparam logic [3:0] RF_ISAR_DEC    = 4'd14;
    localparam logic [3:0] RF_NONE        = 4'd15;

    // opcode groups (high nibble)
    localparam logic [3:0] GRP_DS   = 4'h3;
    localparam logic [3:0] GRP_LRAR = 4'h4;
    localparam logic [3:0] GRP_LRRA = 4'h5;
    localparam logic [3:0] GRP_LIS  = 4'h6;
    localparam logic [3:0] GRP_LISA = 4'h7;
    localparam logic [3:0] GRP_MEM  = 4'h8;
    localparam logic [3:0] GRP_BF   = 4'h9;
    localparam logic [3:0] GRP_INS  = 4'hA;
    localparam logic [3:0] GRP_OUTS = 4'hB;
    localparam logic [3:0] GRP_AS   = 4'hC;
    localparam logic [3:0] GRP_ASD  = 4'hD;
    localparam logic [3:0] GRP_XS   = 4'hE;
    localparam logic [3:0] GRP_NS   = 4'hF;

    localparam logic [7:0] OP_XFER_LAST = 8'h07;
    localparam logic [7:0] OP_LR_KP   = 8'h08;
    localparam logic [7:0] OP_LR_PK   = 8'h09;
    localparam logic [7:0] OP_LR_AIS  = 8'h0A;
    localparam logic [7:0] OP_LR_ISA  = 8'h0B;
    localparam logic [7:0] OP_PK      = 8'h0C;
    localparam logic [7:0] OP_LR_P0Q  = 8'h0D;
    localparam logic [7:0] OP_LR_QDC  = 8'h0E;
    localparam logic [7:0] OP_LR_DCQ  = 8'h0F;
    localparam logic [7:0] OP_LR_DCH  = 8'h10;
    localparam logic [7:0] OP_LR_HDC  = 8'h11;
    localparam logic [7:0] OP_SR1     = 8'h12;
    localparam logic [7:0] OP_SL1     = 8'h13;
    localparam logic [7:0] OP_SR4     = 8'h14;
    localparam logic [7:0] OP_SL4     = 8'h15;
    localparam logic [7:0] OP_LM      = 8'h16;
    localparam logic [7:0] OP_ST      = 8'h17;
    localparam logic [7:0] OP_COM     = 8'h18;
    localparam logic [7:0] OP_LNK     = 8'h19;
    localparam logic [7:0] OP_DI      = 8'h1A;
    localparam logic [7:0] OP_EI      = 8'h1B;
    localparam logic [7:0] OP_POP     = 8'h1C;
    localparam logic [7:0] OP_LR_WJ   = 8'h1D;
    localparam logic [7:0] OP_LR_JW   = 8'h1E;
    localparam logic [7:0] OP_INC     = 8'h1F;
    localparam logic [7:0] OP_LI      = 8'h20;
    localparam logic [7:0] OP_NI      = 8'h21;
    localparam logic [7:0] OP_OI      = 8'h22;
    localparam logic [7:0] OP_XI      = 8'h23;
    localparam logic [7:0] OP_AI      = 8'h24;
    localparam logic [7:0] OP_CI      = 8'h25;
    localparam logic [7:0] OP_IN      = 8'h26;
    localparam logic [7:0] OP_OUT     = 8'h27;
    localparam logic [7:0] OP_PI      = 8'h28;
    localparam logic [7:0] OP_JMP     = 8'h29;
    localparam logic [7:0] OP_DCI     = 8'h2A;
    localparam logic [7:0] OP_NOP     = 8'h2B;
    localparam logic [7:0] OP_XDC     = 8'h2C;

    // low nibble codes in the memory group
    localparam logic [3:0] MOP_AM  = 4'h8;
    localparam logic [3:0] MOP_AMD = 4'h9;
    localparam logic [3:0] MOP_NM  = 4'hA;
    localparam logic [3:0] MOP_OM  = 4'hB;
    localparam logic [3:0] MOP_XM  = 4'hC;
    localparam logic [3:0] MOP_CM  = 4'hD;
    localparam logic [3:0] MOP_ADC = 4'hE;
    localparam logic [3:0] MOP_BR7 = 4'hF;

    localparam logic [3:0] INS_PORT0 = 4'd0;
    localparam logic [3:0] INS_PORT1 = 4'd1;
    localparam logic [3:0] INS_PORT4 = 4'd4;

    typedef struct packed {
        logic [7:0] func;
        logic [7:0] imm_first;
        logic [7:0] imm_second;
        logic [7:0] mem_data;
        logic [7:0] port_data;
    } in_word_t;

    typedef struct packed {
        logic [15:0]       next_pc;
        logic [7:0]        accumulator;
        logic [FLAG_W-1:0] status_flags;
        logic [15:0]       data_counter;
        logic              port_write;
        logic [3:0]        port_number;
        logic [7:0]        port_value;
        logic              store_write;
        logic [15:0]       store_address;
        logic              bad_opcode;
    } out_word_t;

endpackage

// ===== sv/f8ie_in_if.sv =====
`timescale 1ns / 1ps
interface f8ie_in_if;
    import f8ie_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/f8ie_out_if.sv =====
`timescale 1ns / 1ps
interface f8ie_out_if;
    import f8ie_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/f8_instruction_execute_top.sv =====
`timescale 1ns / 1ps
// The edge that takes a word also registers its scratchpad reads; the execute stage
// then executes it and registers the result word.
// Throughput: one instruction per cycle, back to back; a result word held at the output
// stalls the execute stage and, behind it, the input.
// Reset: accumulator, flags, ISAR, PC0/PC1, DC0/DC1 and port latches go to zero;
// scratchpad entries read as 0xFF until first written. No clearing pass.
module f8_instruction_execute_top #(
    parameter int PORT_COUNT = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    f8ie_in_if.sink    in_word,
    f8ie_out_if.source out_word
);
    import f8ie_pkg::*;

    localparam int PW = $clog2(PORT_COUNT);

    logic [7:0]        acc_reg, acc_next;
    logic [FLAG_W-1:0] flag_reg, flag_next;
    logic [5:0]        isar_reg, isar_next;
    logic [15:0]       pc0_reg, pc0_next;
    logic [15:0]       pc1_reg, pc1_next;
    logic [15:0]       dc0_reg, dc0_next;
    logic [15:0]       dc1_reg, dc1_next;
    logic [7:0]        scratch_reg [SCRATCH_DEPTH];
    logic [SCRATCH_DEPTH-1:0] scratch_vld_reg;
    logic [7:0]        latch_reg   [PORT_COUNT];
    out_word_t         out_reg, out_next;
    logic              out_valid_reg;

    in_word_t          ex_word_reg;
    logic              ex_valid_reg;
    logic              ex_fire;
    logic [7:0]        sp_rd0_reg, sp_rd1_reg;
    logic [7:0]        sp_ovr0_reg, sp_ovr0_next, sp_ovr1_reg, sp_ovr1_next;
    logic              sp_ovr0_en_reg, sp_ovr0_en_next, sp_ovr1_en_reg, sp_ovr1_en_next;
    logic [7:0]        sp0, sp1;
    logic [7:0]        nx_op;
    logic [3:0]        nx_lo;
    logic [5:0]        isar_eff;
    logic [SCRATCH_AW-1:0] ra0, ra1;

    logic       accept;
    logic [7:0] op, i1, mem, pin;
    logic [3:0] hi, lo;
    logic [15:0] pc_plus1, pc_plus2, pc_plus3, br_target, addr;
    logic [5:0] reg_idx, isar_step;
    logic [7:0] reg_val;
    logic [15:0] rd_pair;
    logic [PW-1:0] in_port;

    logic              we0, we1;
    logic [SCRATCH_AW-1:0] a0, a1;
    logic [7:0]        d0, d1;
    logic              lat_we;
    logic [PW-1:0]     lat_a;
    logic [7:0]        lat_d;
    logic [7:0]        ins_val;

    logic [7:0]        alu_a, alu_b, alu_res;
    logic              alu_cin, alu_dec, use_alu;
    logic [FLAG_W-1:0] alu_flags;

    assign ex_fire        = ex_valid_reg && (!out_valid_reg || out_word.ready);
    assign in_word.ready  = !ex_valid_reg || ex_fire;
    assign accept         = in_word.valid && in_word.ready;
    assign out_word.valid = out_valid_reg;
    assign out_word.data  = out_reg;

    // scratchpad read addresses for the incoming word
    assign nx_op    = in_word.data.func;
    assign nx_lo    = nx_op[3:0];
    assign isar_eff = ex_fire ? isar_next : isar_reg;

    always_comb
    begin
        ra0 = (nx_lo <= RF_DIRECT_LAST) ? {2'b00, nx_lo} : isar_eff;
        ra1 = SR_KL;
        if (nx_op <= OP_XFER_LAST)
        begin
            ra0 = SR_KU + {4'd0, nx_op[1:0]};
        end
        else
        begin
            case (nx_op)
                OP_LR_PK, OP_PK:
                begin
                    ra0 = SR_KU;
                    ra1 = SR_KL;
                end
                OP_LR_P0Q, OP_LR_DCQ:
                begin
                    ra0 = SR_QU;
                    ra1 = SR_QL;
                end
                OP_LR_DCH:
                begin
                    ra0 = SR_HU;
                    ra1 = SR_HL;
                end
                OP_LR_WJ:
                begin
                    ra0 = SR_J;
                end
                default:
                begin
                end
            endcase
        end
    end

    // unwritten bytes read as 0xFF; a write by the word leaving execute lands at the same edge
    always_comb
    begin
        sp_ovr0_en_next = !scratch_vld_reg[ra0];
        sp_ovr0_next    = 8'hFF;
        sp_ovr1_en_next = !scratch_vld_reg[ra1];
        sp_ovr1_next    = 8'hFF;
        if (ex_fire && we0 && a0 == ra0)
        begin
            sp_ovr0_en_next = 1'b1;
            sp_ovr0_next    = d0;
        end
        if (ex_fire && we1 && a1 == ra0)
        begin
            sp_ovr0_en_next = 1'b1;
            sp_ovr0_next    = d1;
        end
        if (ex_fire && we0 && a0 == ra1)
        begin
            sp_ovr1_en_next = 1'b1;
            sp_ovr1_next    = d0;
        end
        if (ex_fire && we1 && a1 == ra1)
        begin
            sp_ovr1_en_next = 1'b1;
            sp_ovr1_next    = d1;
        end
    end

    assign sp0 = sp_ovr0_en_reg ? sp_ovr0_reg : sp_rd0_reg;
    assign sp1 = sp_ovr1_en_reg ? sp_ovr1_reg : sp_rd1_reg;

    assign op  = ex_word_reg.func;
    assign i1  = ex_word_reg.imm_first;
    assign mem = ex_word_reg.mem_data;
    assign pin = ex_word_reg.port_data;
    assign hi  = op[7:4];
    assign lo  = op[3:0];
    assign addr      = {i1, ex_word_reg.imm_second};
    assign pc_plus1  = pc0_reg + 16'd1;
    assign pc_plus2  = pc0_reg + 16'd2;
    assign pc_plus3  = pc0_reg + 16'd3;
    assign br_target = pc_plus1 + {{8{i1[7]}}, i1};
    assign in_port   = PW'(i1);

    assign rd_pair = {sp0, sp1};
    assign reg_idx = (lo <= RF_DIRECT_LAST) ? {2'b00, lo} : isar_reg;
    assign reg_val = sp0;

    // octal auto increment / decrement stays within the low three bits
    always_comb
    begin
        isar_step = isar_reg;
        if (lo == RF_ISAR_INC)
        begin
            isar_step[2:0] = isar_reg[2:0] + 3'd1;
        end
        else if (lo == RF_ISAR_DEC)
        begin
            isar_step[2:0] = isar_reg[2:0] - 3'd1;
        end
    end

    f8ie_alu u_alu (
        .op_a    (alu_a),
        .op_b    (alu_b),
        .cin     (alu_cin),
        .decimal (alu_dec),
        .icb     (flag_reg[FLAG_ICB]),
        .result  (alu_res),
        .flags   (alu_flags)
    );

    always_comb
    begin
        acc_next  = acc_reg;
        isar_next = isar_reg;
        pc0_next  = pc_plus1;
        pc1_next  = pc1_reg;
        dc0_next  = dc0_reg;
        dc1_next  = dc1_reg;
        we0 = 1'b0; a0 = reg_idx; d0 = acc_reg;
        we1 = 1'b0; a1 = SR_KL;   d1 = acc_reg;
        lat_we = 1'b0; lat_a = PW'(lo); lat_d = acc_reg;
        ins_val = latch_reg[PW'(lo)];
        alu_a = acc_reg; alu_b = 8'd0; alu_cin = 1'b0; alu_dec = 1'b0;
        use_alu = 1'b0;
        out_next = '0;

        if (lo == RF_NONE && hi >= GRP_DS && (hi <= GRP_LRRA || hi >= GRP_AS))
        begin
            out_next.bad_opcode = 1'b1;
        end
        else if (op <= OP_XFER_LAST)
        begin
            if (op[2])
            begin
                we0 = 1'b1;
                a0  = SR_KU + {4'd0, op[1:0]};
            end
            else
            begin
                acc_next = sp0;
            end
        end
        else
        begin
            case (hi)
                GRP_DS:
                begin
                    isar_next = isar_step;
                    alu_a = reg_val; alu_b = 8'hFF; use_alu = 1'b1;
                    we0 = 1'b1; d0 = alu_res;
                end
                GRP_LRAR:
                begin
                    isar_next = isar_step;
                    acc_next  = reg_val;
                end
                GRP_LRRA:
                begin
                    isar_next = isar_step;
                    we0 = 1'b1;
                end
                GRP_LIS:
                begin
                    if (lo[3])
                    begin
                        isar_next[2:0] = lo[2:0];
                    end
                    else
                    begin
                        isar_next[5:3] = lo[2:0];
                    end
                end
                GRP_LISA:
                begin
                    acc_next = {4'd0, lo};
                end
                GRP_MEM:
                begin
                    if (!lo[3])
                    begin
                        pc0_next = ((lo[2:0] & flag_reg[2:0]) != 3'd0) ? br_target : pc_plus2;
                    end
                    else
                    begin
                        case (lo)
                            MOP_AM:
                            begin
                                alu_b = mem; use_alu = 1'b1; acc_next = alu_res;
                                dc0_next = dc0_reg + 16'd1;
                            end
                            MOP_AMD:
                            begin
                                alu_b = mem; alu_dec = 1'b1; use_alu = 1'b1;
                                acc_next = alu_res; dc0_next = dc0_reg + 16'd1;
                            end
                            MOP_NM:
                            begin
                                alu_a = acc_reg & mem; use_alu = 1'b1; acc_next = alu_res;
                                dc0_next = dc0_reg + 16'd1;
                            end
                            MOP_OM:
                            begin
                                alu_a = acc_reg | mem; use_alu = 1'b1; acc_next = alu_res;
                                dc0_next = dc0_reg + 16'd1;
                            end
                            MOP_XM:
                            begin
                                alu_a = acc_reg ^ mem; use_alu = 1'b1; acc_next = alu_res;
                                dc0_next = dc0_reg + 16'd1;
                            end
                            MOP_CM:
                            begin
                                alu_a = mem; alu_b = ~acc_reg; alu_cin = 1'b1;
                                use_alu = 1'b1; dc0_next = dc0_reg + 16'd1;
                            end
                            MOP_ADC:
                            begin
                                dc0_next = dc0_reg + {{8{acc_reg[7]}}, acc_reg};
                            end
                            default:
                            begin
                                pc0_next = (isar_reg[2:0] != 3'b111) ? br_target : pc_plus2;
                            end
                        endcase
                    end
                end
                GRP_BF:
                begin
                    pc0_next = ((lo & flag_reg[3:0]) == 4'd0) ? br_target : pc_plus2;
                end
                GRP_INS:
                begin
                    if (lo == INS_PORT0 ||
                        ((lo == INS_PORT1 || lo == INS_PORT4) &&
                         latch_reg[PW'(lo)] == 8'd0))
                    begin
                        lat_we  = 1'b1;
                        lat_d   = pin;
                        ins_val = pin;
                    end
                    alu_a = ins_val; use_alu = 1'b1; acc_next = alu_res;
                end
                GRP_OUTS:
                begin
                    lat_we = 1'b1;
                    out_next.port_write  = 1'b1;
                    out_next.port_number = lo;
                    out_next.port_value  = acc_reg;
                end
                GRP_AS, GRP_ASD, GRP_XS, GRP_NS:
                begin
                    isar_next = isar_step;
                    use_alu   = 1'b1;
                    acc_next  = alu_res;
                    case (hi)
                        GRP_AS:  alu_b = reg_val;
                        GRP_ASD:
                        begin
                            alu_b   = reg_val;
                            alu_dec = 1'b1;
                        end
                        GRP_XS:  alu_a = acc_reg ^ reg_val;
                        default: alu_a = acc_reg & reg_val;
                    endcase
                end
                default:
                begin
                    case (op)
                        OP_LR_KP:
                        begin
                            we0 = 1'b1; a0 = SR_KU; d0 = pc1_reg[15:8];
                            we1 = 1'b1; a1 = SR_KL; d1 = pc1_reg[7:0];
                        end
                        OP_LR_PK:  pc1_next = rd_pair;
                        OP_LR_AIS: acc_next = {2'b00, isar_reg};
                        OP_LR_ISA: isar_next = acc_reg[5:0];
                        OP_PK:
                        begin
                            pc1_next = pc_plus1;
                            pc0_next = rd_pair;
                        end
                        OP_LR_P0Q: pc0_next = rd_pair;
                        OP_LR_QDC:
                        begin
                            we0 = 1'b1; a0 = SR_QU; d0 = dc0_reg[15:8];
                            we1 = 1'b1; a1 = SR_QL; d1 = dc0_reg[7:0];
                        end
                        OP_LR_DCQ: dc0_next = rd_pair;
                        OP_LR_DCH: dc0_next = rd_pair;
                        OP_LR_HDC:
                        begin
                            we0 = 1'b1; a0 = SR_HU; d0 = dc0_reg[15:8];
                            we1 = 1'b1; a1 = SR_HL; d1 = dc0_reg[7:0];
                        end
                        // shifts set flags as a logical op on the shifted value
                        OP_SR1:
                        begin
                            alu_a = {1'b0, acc_reg[7:1]}; use_alu = 1'b1; acc_next = alu_res;
                        end
                        OP_SL1:
                        begin
                            alu_a = {acc_reg[6:0], 1'b0}; use_alu = 1'b1; acc_next = alu_res;
                        end
                        OP_SR4:
                        begin
                            alu_a = {4'd0, acc_reg[7:4]}; use_alu = 1'b1; acc_next = alu_res;
                        end
                        OP_SL4:
                        begin
                            alu_a = {acc_reg[3:0], 4'd0}; use_alu = 1'b1; acc_next = alu_res;
                        end
                        OP_LM:
                        begin
                            acc_next = mem;
                            dc0_next = dc0_reg + 16'd1;
                        end
                        OP_ST:
                        begin
                            out_next.store_write   = 1'b1;
                            out_next.store_address = dc0_reg;
                            dc0_next = dc0_reg + 16'd1;
                        end
                        OP_COM:
                        begin
                            alu_a = ~acc_reg; use_alu = 1'b1; acc_next = alu_res;
                        end
                        OP_LNK:
                        begin
                            alu_b = {7'd0, flag_reg[FLAG_CARRY]}; use_alu = 1'b1;
                            acc_next = alu_res;
                        end
                        OP_DI, OP_EI, OP_LR_WJ, OP_NOP:
                        begin
                        end
                        OP_POP:    pc0_next = pc1_reg;
                        OP_LR_JW:
                        begin
                            we0 = 1'b1; a0 = SR_J; d0 = {3'd0, flag_reg};
                        end
                        OP_INC:
                        begin
                            alu_b = 8'd1; use_alu = 1'b1; acc_next = alu_res;
                        end
                        OP_LI:
                        begin
                            acc_next = i1; pc0_next = pc_plus2;
                        end
                        OP_NI:
                        begin
                            alu_a = acc_reg & i1; use_alu = 1'b1; acc_next = alu_res;
                            pc0_next = pc_plus2;
                        end
                        OP_OI:
                        begin
                            alu_a = acc_reg | i1; use_alu = 1'b1; acc_next = alu_res;
                            pc0_next = pc_plus2;
                        end
                        OP_XI:
                        begin
                            alu_a = acc_reg ^ i1; use_alu = 1'b1; acc_next = alu_res;
                            pc0_next = pc_plus2;
                        end
                        OP_AI:
                        begin
                            alu_b = i1; use_alu = 1'b1; acc_next = alu_res;
                            pc0_next = pc_plus2;
                        end
                        OP_CI:
                        begin
                            alu_a = i1; alu_b = ~acc_reg; alu_cin = 1'b1; use_alu = 1'b1;
                            pc0_next = pc_plus2;
                        end
                        OP_IN:
                        begin
                            alu_a = latch_reg[in_port]; use_alu = 1'b1; acc_next = alu_res;
                            pc0_next = pc_plus2;
                        end
                        OP_OUT:
                        begin
                            lat_we = 1'b1; lat_a = in_port;
                            out_next.port_write  = 1'b1;
                            out_next.port_number = i1[3:0];
                            out_next.port_value  = acc_reg;
                            pc0_next = pc_plus2;
                        end
                        OP_PI:
                        begin
                            acc_next = i1; pc1_next = pc_plus3; pc0_next = addr;
                        end
                        OP_JMP:
                        begin
                            acc_next = i1; pc0_next = addr;
                        end
                        OP_DCI:
                        begin
                            dc0_next = addr; pc0_next = pc_plus3;
                        end
                        OP_XDC:
                        begin
                            dc0_next = dc1_reg; dc1_next = dc0_reg;
                        end
                        default: out_next.bad_opcode = 1'b1;
                    endcase
                end
            endcase
        end

        flag_next = flag_reg;
        if (use_alu)
        begin
            flag_next = alu_flags;
        end
        else if (!out_next.bad_opcode && op == OP_DI)
        begin
            flag_next[FLAG_ICB] = 1'b0;
        end
        else if (!out_next.bad_opcode && op == OP_EI)
        begin
            flag_next[FLAG_ICB] = 1'b1;
        end
        else if (!out_next.bad_opcode && op == OP_LR_WJ)
        begin
            flag_next = sp0[FLAG_W-1:0];
        end

        out_next.next_pc      = pc0_next;
        out_next.accumulator  = acc_next;
        out_next.status_flags = flag_next;
        out_next.data_counter = dc0_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            flag_reg <= '0;
            isar_reg <= '0;
            pc0_reg  <= '0;
            pc1_reg  <= '0;
            dc0_reg  <= '0;
            dc1_reg  <= '0;
            scratch_vld_reg <= '0;
            out_valid_reg   <= 1'b0;
            ex_valid_reg    <= 1'b0;
            sp_ovr0_reg     <= '0;
            sp_ovr1_reg     <= '0;
            sp_ovr0_en_reg  <= 1'b0;
            sp_ovr1_en_reg  <= 1'b0;
            for (int i = 0; i < PORT_COUNT; i++)
            begin
                latch_reg[i] <= '0;
            end
        end
        else
        begin
            if (ex_fire)
            begin
                acc_reg  <= acc_next;
                flag_reg <= flag_next;
                isar_reg <= isar_next;
                pc0_reg  <= pc0_next;
                pc1_reg  <= pc1_next;
                dc0_reg  <= dc0_next;
                dc1_reg  <= dc1_next;
                if (we0)
                begin
                    scratch_vld_reg[a0] <= 1'b1;
                end
                if (we1)
                begin
                    scratch_vld_reg[a1] <= 1'b1;
                end
                if (lat_we)
                begin
                    latch_reg[lat_a] <= lat_d;
                end
            end
            if (accept)
            begin
                sp_ovr0_reg    <= sp_ovr0_next;
                sp_ovr1_reg    <= sp_ovr1_next;
                sp_ovr0_en_reg <= sp_ovr0_en_next;
                sp_ovr1_en_reg <= sp_ovr1_en_next;
            end
            if (accept)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_word.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_word_reg <= in_word.data;
            sp_rd0_reg  <= scratch_reg[ra0];
            sp_rd1_reg  <= scratch_reg[ra1];
        end
        if (ex_fire)
        begin
            out_reg <= out_next;
            if (we0)
            begin
                scratch_reg[a0] <= d0;
            end
            if (we1)
            begin
                scratch_reg[a1] <= d1;
            end
        end
    end

    // the reported counters always mirror the architectural registers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.next_pc == pc0_reg && out_reg.data_counter == dc0_reg))
        else $error("result counters differ from PC0/DC0");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.store_write) |->
            (out_reg.store_address + 16'd1 == dc0_reg))
        else $error("store address is not the data counter before increment");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.port_write && out_reg.store_write))
        else $error("port and store write in one word");

    assert property (@(posedge clk) disable iff (!rst_n)
        ex_fire |=> out_valid_reg)
        else $error("executed word produced no result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ex_fire && out_next.bad_opcode) |=>
            (out_reg.next_pc == $past(pc_plus1) && acc_reg == $past(acc_reg)))
        else $error("undefined opcode changed state");

endmodule

// ===== sv/f8ie_alu.sv =====
`timescale 1ns / 1ps
module f8ie_alu (
    input  logic [7:0]                  op_a,
    input  logic [7:0]                  op_b,
    input  logic                        cin,
    input  logic                        decimal,
    input  logic                        icb,
    output logic [7:0]                  result,
    output logic [f8ie_pkg::FLAG_W-1:0] flags
);
    import f8ie_pkg::*;

    logic [8:0] sum;
    logic [4:0] low_sum;
    logic [7:0] bin;
    logic       carry;
    logic       low_carry;

    assign sum       = {1'b0, op_a} + {1'b0, op_b} + {8'd0, cin};
    assign low_sum   = {1'b0, op_a[3:0]} + {1'b0, op_b[3:0]};
    assign bin       = sum[7:0];
    assign carry     = sum[8];
    assign low_carry = low_sum[4];

    // decimal adjust: add 0xA (mod 16) to each digit that gave no carry
    always_comb
    begin
        result = bin;
        if (decimal)
        begin
            result[7:4] = carry ? bin[7:4] : bin[7:4] + 4'hA;
            result[3:0] = low_carry ? bin[3:0] : bin[3:0] + 4'hA;
        end
    end

    always_comb
    begin
        flags             = '0;
        flags[FLAG_ICB]   = icb;
        flags[FLAG_CARRY] = carry;
        flags[FLAG_OVF]   = (op_a[7] ^ bin[7]) & (op_b[7] ^ bin[7]);
        flags[FLAG_ZERO]  = (bin == 8'd0);
        flags[FLAG_SIGN]  = ~bin[7];
    end

endmodule

// ===== dv/f8ie_checker.sv =====
`timescale 1ns / 1ps
module f8ie_checker #(
    parameter int PORT_COUNT = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  f8ie_pkg::in_word_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  f8ie_pkg::out_word_t out_data,
    output int                  errors,
    output int                  pending,
    output int                  n_bad,
    output int                  n_store,
    output int                  n_port
);
    import f8ie_pkg::*;

    logic [7:0]        acc;
    logic [FLAG_W-1:0] flags;
    logic [5:0]        isar;
    logic [7:0]        scratch [SCRATCH_DEPTH];
    logic [15:0]       pc0, pc1, dc0, dc1;
    logic [7:0]        latch [PORT_COUNT];
    out_word_t         results_due [$];

    function automatic logic [7:0] add8(input logic [7:0] a, input logic [7:0] b,
                                        input logic cin);
        logic [8:0]        s;
        logic [7:0]        r;
        logic [FLAG_W-1:0] f;
        s = {1'b0, a} + {1'b0, b} + {8'd0, cin};
        r = s[7:0];
        f = '0;
        f[FLAG_ICB]   = flags[FLAG_ICB];
        f[FLAG_CARRY] = s[8];
        f[FLAG_OVF]   = (a[7] ^ r[7]) & (b[7] ^ r[7]);
        f[FLAG_ZERO]  = (r == 8'd0);
        f[FLAG_SIGN]  = ~r[7];
        flags = f;
        return r;
    endfunction

    function automatic logic [7:0] dec_add(input logic [7:0] a, input logic [7:0] b);
        logic [8:0] s;
        logic [7:0] t;
        logic       c, ic;
        s  = {1'b0, a} + {1'b0, b};
        t  = s[7:0];
        c  = s[8];
        ic = ({1'b0, a[3:0]} + {1'b0, b[3:0]}) > 5'd15;
        void'(add8(a, b, 1'b0));
        // digits with no carry out get 6 taken off
        if (!c)
            t[7:4] = t[7:4] + 4'ha;
        if (!ic)
            t[3:0] = t[3:0] + 4'ha;
        return t;
    endfunction

    function automatic void shift_a(input logic right, input int amount);
        acc = right ? acc >> amount : acc << amount;
        flags = flags & FLAG_W'(1 << FLAG_ICB);
        flags[FLAG_ZERO] = (acc == 8'd0);
        flags[FLAG_SIGN] = ~acc[7];
    endfunction

    function automatic int sp_index(input logic [3:0] r);
        int i;
        if (r <= RF_DIRECT_LAST)
            return int'(r);
        i = int'(isar);
        if (r == RF_ISAR_INC)
            isar[2:0] = isar[2:0] + 3'd1;
        else if (r == RF_ISAR_DEC)
            isar[2:0] = isar[2:0] - 3'd1;
        return i;
    endfunction

    function automatic logic [15:0] pair(input int hi);
        return {scratch[hi], scratch[hi + 1]};
    endfunction

    function automatic void set_pair(input int hi, input logic [15:0] v);
        scratch[hi]     = v[15:8];
        scratch[hi + 1] = v[7:0];
    endfunction

    function automatic out_word_t execute(input in_word_t w);
        out_word_t   o;
        logic [7:0]  op;
        logic [3:0]  hi, lo;
        logic [15:0] nxt, target, skip, t;
        int          idx, p;
        op = w.func;
        hi = op[7:4];
        lo = op[3:0];
        nxt = pc0 + 16'd1;
        target = pc0 + 16'd1 + {{8{w.imm_first[7]}}, w.imm_first};
        skip = pc0 + 16'd2;
        o = '0;
        if (hi >= GRP_DS && !(hi inside {GRP_LIS, GRP_LISA, GRP_MEM, GRP_BF, GRP_INS,
                                         GRP_OUTS}) && lo == RF_NONE) begin
            o.bad_opcode = 1'b1;
        end else if (op <= OP_XFER_LAST) begin
            idx = int'(SR_KU) + int'(op[1:0]);
            if (!op[2]) acc = scratch[idx];
            else scratch[idx] = acc;
        end else if (hi <= 4'd2) begin
            case (op)
                OP_LR_KP:  set_pair(SR_KU, pc1);
                OP_LR_PK:  pc1 = pair(SR_KU);
                OP_LR_AIS: acc = {2'b00, isar};
                OP_LR_ISA: isar = acc[5:0];
                OP_PK:
                begin
                    pc1 = nxt;
                    nxt = pair(SR_KU);
                end
                OP_LR_P0Q: nxt = pair(SR_QU);
                OP_LR_QDC: set_pair(SR_QU, dc0);
                OP_LR_DCQ: dc0 = pair(SR_QU);
                OP_LR_DCH: dc0 = pair(SR_HU);
                OP_LR_HDC: set_pair(SR_HU, dc0);
                OP_SR1:    shift_a(1'b1, 1);
                OP_SL1:    shift_a(1'b0, 1);
                OP_SR4:    shift_a(1'b1, 4);
                OP_SL4:    shift_a(1'b0, 4);
                OP_LM:
                begin
                    acc = w.mem_data;
                    dc0++;
                end
                OP_ST:
                begin
                    o.store_write = 1'b1;
                    o.store_address = dc0;
                    dc0++;
                end
                OP_COM:    acc = add8(~acc, 8'd0, 1'b0);
                OP_LNK:    acc = add8(acc, {7'd0, flags[FLAG_CARRY]}, 1'b0);
                OP_DI:     flags[FLAG_ICB] = 1'b0;
                OP_EI:     flags[FLAG_ICB] = 1'b1;
                OP_POP:    nxt = pc1;
                OP_LR_WJ:  flags = scratch[SR_J][FLAG_W-1:0];
                OP_LR_JW:  scratch[SR_J] = {3'd0, flags};
                OP_INC:    acc = add8(acc, 8'd1, 1'b0);
                OP_LI:
                begin
                    acc = w.imm_first;
                    nxt = skip;
                end
                OP_NI:
                begin
                    acc = add8(acc & w.imm_first, 8'd0, 1'b0);
                    nxt = skip;
                end
                OP_OI:
                begin
                    acc = add8(acc | w.imm_first, 8'd0, 1'b0);
                    nxt = skip;
                end
                OP_XI:
                begin
                    acc = add8(acc ^ w.imm_first, 8'd0, 1'b0);
                    nxt = skip;
                end
                OP_AI:
                begin
                    acc = add8(acc, w.imm_first, 1'b0);
                    nxt = skip;
                end
                OP_CI:
                begin
                    void'(add8(w.imm_first, ~acc, 1'b1));
                    nxt = skip;
                end
                OP_IN:
                begin
                    acc = add8(latch[w.imm_first % PORT_COUNT], 8'd0, 1'b0);
                    nxt = skip;
                end
                OP_OUT:
                begin
                    p = w.imm_first % PORT_COUNT;
                    latch[p] = acc;
                    o.port_write = 1'b1;
                    o.port_number = p[3:0];
                    o.port_value = acc;
                    nxt = skip;
                end
                OP_PI:
                begin
                    acc = w.imm_first;
                    pc1 = pc0 + 16'd3;
                    nxt = {w.imm_first, w.imm_second};
                end
                OP_JMP:
                begin
                    acc = w.imm_first;
                    nxt = {w.imm_first, w.imm_second};
                end
                OP_DCI:
                begin
                    dc0 = {w.imm_first, w.imm_second};
                    nxt = pc0 + 16'd3;
                end
                OP_NOP: ;
                OP_XDC:
                begin
                    t = dc0;
                    dc0 = dc1;
                    dc1 = t;
                end
                default: o.bad_opcode = 1'b1;
            endcase
        end else if (hi == GRP_DS) begin
            idx = sp_index(lo);
            scratch[idx] = add8(scratch[idx], 8'hff, 1'b0);
        end else if (hi == GRP_LRAR) begin
            acc = scratch[sp_index(lo)];
        end else if (hi == GRP_LRRA) begin
            scratch[sp_index(lo)] = acc;
        end else if (hi == GRP_LIS) begin
            if (!lo[3]) isar[5:3] = lo[2:0];
            else isar[2:0] = lo[2:0];
        end else if (hi == GRP_LISA) begin
            acc = {4'd0, lo};
        end else if (hi == GRP_MEM) begin
            if (!lo[3]) begin
                nxt = ({1'b0, lo[2:0]} & flags[3:0]) != 0 ? target : skip;
            end else begin
                case (lo)
                    MOP_AM:  acc = add8(acc, w.mem_data, 1'b0);
                    MOP_AMD: acc = dec_add(acc, w.mem_data);
                    MOP_NM:  acc = add8(acc & w.mem_data, 8'd0, 1'b0);
                    MOP_OM:  acc = add8(acc | w.mem_data, 8'd0, 1'b0);
                    MOP_XM:  acc = add8(acc ^ w.mem_data, 8'd0, 1'b0);
                    MOP_CM:  void'(add8(w.mem_data, ~acc, 1'b1));
                    MOP_ADC: dc0 = dc0 + {{8{acc[7]}}, acc};
                    default: nxt = isar[2:0] != 3'd7 ? target : skip;
                endcase
                if (lo != MOP_ADC && lo != MOP_BR7)
                    dc0++;
            end
        end else if (hi == GRP_BF) begin
            nxt = ({1'b0, lo} & flags) == 0 ? target : skip;
        end else if (hi == GRP_INS) begin
            if (lo == INS_PORT0) latch[0] = w.port_data;
            else if (lo == INS_PORT1 && latch[1] == 0) latch[1] = w.port_data;
            else if (lo == INS_PORT4 && latch[4] == 0) latch[4] = w.port_data;
            acc = add8(latch[lo], 8'd0, 1'b0);
        end else if (hi == GRP_OUTS) begin
            latch[lo] = acc;
            o.port_write = 1'b1;
            o.port_number = lo;
            o.port_value = acc;
        end else if (hi == GRP_AS) begin
            acc = add8(acc, scratch[sp_index(lo)], 1'b0);
        end else if (hi == GRP_ASD) begin
            acc = dec_add(acc, scratch[sp_index(lo)]);
        end else if (hi == GRP_XS) begin
            acc = add8(acc ^ scratch[sp_index(lo)], 8'd0, 1'b0);
        end else begin
            acc = add8(acc & scratch[sp_index(lo)], 8'd0, 1'b0);
        end
        pc0 = nxt;
        o.next_pc = pc0;
        o.accumulator = acc;
        o.status_flags = flags;
        o.data_counter = dc0;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n) begin
            acc = '0;
            flags = '0;
            isar = '0;
            pc0 = '0;
            pc1 = '0;
            dc0 = '0;
            dc1 = '0;
            foreach (scratch[i]) scratch[i] = 8'hff;
            foreach (latch[i]) latch[i] = '0;
            results_due.delete();
            errors = 0;
            pending = 0;
            n_bad = 0;
            n_store = 0;
            n_port = 0;
        end else begin
            // output first: a word taken this edge shows up at a later one
            if (out_valid && out_ready) begin
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word %h", $time, out_data);
                end else begin
                    exp_w = results_due.pop_front();
                    if (out_data !== exp_w) begin
                        errors++;
                        $display("%0t: mismatch expected %h actual %h", $time,
                                 exp_w, out_data);
                        $display("  pc %h/%h a %h/%h w %h/%h dc %h/%h", exp_w.next_pc,
                                 out_data.next_pc, exp_w.accumulator,
                                 out_data.accumulator, exp_w.status_flags,
                                 out_data.status_flags, exp_w.data_counter,
                                 out_data.data_counter);
                    end
                end
            end
            if (in_valid && in_ready) begin
                exp_w = execute(in_data);
                n_bad += int'(exp_w.bad_opcode);
                n_store += int'(exp_w.store_write);
                n_port += int'(exp_w.port_write);
                results_due.push_back(exp_w);
            end
            pending = results_due.size();
        end
    end

endmodule

// ===== dv/f8_instruction_execute_top_tb.sv =====
`timescale 1ns / 1ps
module f8_instruction_execute_top_tb;
    import f8ie_pkg::*;

    localparam int N_RANDOM = 1400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors, pending, n_bad, n_store, n_port;

    f8ie_in_if  in_word ();
    f8ie_out_if out_word ();

    f8_instruction_execute_top #(.PORT_COUNT(16)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_word (in_word.sink),
        .out_word(out_word.source)
    );

    f8ie_checker #(.PORT_COUNT(16)) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_word.valid),
        .in_ready (in_word.ready),
        .in_data  (in_word.data),
        .out_valid(out_word.valid),
        .out_ready(out_word.ready),
        .out_data (out_word.data),
        .errors   (errors),
        .pending  (pending),
        .n_bad    (n_bad),
        .n_store  (n_store),
        .n_port   (n_port)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        in_word.valid = 1'b0;
        in_word.data = '0;
        out_word.ready = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("f8_instruction_execute_top test failed");
        $finish;
    end

    // sink side: random stall per word, with calm stretches
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            repeat (gap) @(posedge clk);
            out_word.ready <= 1'b1;
            do @(posedge clk); while (!out_word.valid);
            out_word.ready <= 1'b0;
        end
    end

    task automatic send(input in_word_t w);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            in_word.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word.valid <= 1'b1;
        in_word.data <= w;
        do @(posedge clk); while (!in_word.ready);
    endtask

    function automatic in_word_t rand_word(input logic [7:0] op);
        in_word_t w;
        w.func = op;
        w.imm_first = 8'($urandom_range(0, 255));
        w.imm_second = 8'($urandom_range(0, 255));
        w.mem_data = 8'($urandom_range(0, 255));
        w.port_data = 8'($urandom_range(0, 255));
        return w;
    endfunction

    // mostly real opcodes, short branches mixed in
    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 9))
            0:       return {GRP_MEM, 4'($urandom_range(0, 15))};
            1:       return {GRP_BF, 4'($urandom_range(0, 15))};
            2:       return {4'($urandom_range(0, 2)), 4'($urandom_range(0, 15))};
            3:       return {GRP_LIS, 4'($urandom_range(0, 15))};
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        in_word_t w;
        logic [7:0] dir_ops [] = '{OP_LI, OP_LR_ISA, 8'h5c, 8'h5d, 8'h5e, 8'h4c, 8'h4e,
                                   8'h3d, OP_AI, 8'hd0, OP_ST, OP_DCI, OP_OUT, OP_IN,
                                   8'ha1, 8'ha4, 8'ha0, 8'hbf, 8'h8f, 8'h90, 8'h84,
                                   8'h3f, 8'h2d, OP_XDC, 8'h89};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_ops[i]) begin
            w = rand_word(dir_ops[i]);
            if (i == 0) w.imm_first = 8'hff;
            if (i == 8) w.imm_first = 8'h80;
            if (i == 11) {w.imm_first, w.imm_second} = 16'hffff;
            if (i == 19) w.imm_first = 8'h7f;
            send(w);
        end
        repeat (N_RANDOM) send(rand_word(pick_op()));
        in_word.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        $display("ran %0d instructions: %0d undefined, %0d stores, %0d port writes",
                 N_RANDOM + dir_ops.size(), n_bad, n_store, n_port);
        if (errors == 0)
            $display("f8_instruction_execute_top test passed");
        else
            $display("f8_instruction_execute_top test failed");
        $finish;
    end

endmodule

// ===== f8_instruction_execute_top.f =====
sv/f8ie_pkg.sv
sv/f8ie_in_if.sv
sv/f8ie_out_if.sv
sv/f8ie_alu.sv
sv/f8_instruction_execute_top.sv
dv/f8ie_checker.sv
dv/f8_instruction_execute_top_tb.sv
